// ===== design/iupac_mmc_pkg.sv =====
package iupac_mmc_pkg;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 64;

	// The pattern register holds sixteen 4-bit base-set masks.
	localparam int PATTERN_SLOTS = 16;

	// Configuration register indexes; index 3 is unused and ignored.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_CODES  = 2'd0,
		CFG_PATTERN_LENGTH = 2'd1,
		CFG_REPEAT_COUNT   = 2'd2
	} cfg_reg_t;

	// One bit per nucleotide in a base set.
	localparam logic [3:0] BASE_A = 4'h1;
	localparam logic [3:0] BASE_T = 4'h2;
	localparam logic [3:0] BASE_G = 4'h4;
	localparam logic [3:0] BASE_C = 4'h8;

	// Pipeline steering from the handshake logic to the datapath.
	typedef struct packed {
		logic capture;
		logic process;
	} step_t;

	// Tab, line feed, vertical tab, form feed, carriage return and space.
	function automatic logic is_space(input logic [7:0] b);
		logic sp;
		sp = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
		return sp;
	endfunction

	// Case-insensitive IUPAC letter to base set; anything else is the empty set.
	function automatic logic [3:0] encode_base(input logic [7:0] b);
		logic [7:0] u;
		logic [3:0] code;
		u = ((b >= 8'h61) && (b <= 8'h7A)) ? (b - 8'd32) : b;
		unique case (u)
			8'h41: code = BASE_A;
			8'h54: code = BASE_T;
			8'h47: code = BASE_G;
			8'h43: code = BASE_C;
			8'h4D: code = BASE_A | BASE_C;
			8'h52: code = BASE_A | BASE_G;
			8'h57: code = BASE_A | BASE_T;
			8'h53: code = BASE_C | BASE_G;
			8'h59: code = BASE_C | BASE_T;
			8'h4B: code = BASE_G | BASE_T;
			8'h56: code = BASE_A | BASE_C | BASE_G;
			8'h48: code = BASE_A | BASE_C | BASE_T;
			8'h44: code = BASE_A | BASE_G | BASE_T;
			8'h42: code = BASE_C | BASE_G | BASE_T;
			8'h58, 8'h4E: code = BASE_A | BASE_T | BASE_G | BASE_C;
			default: code = 4'h0;
		endcase
		return code;
	endfunction

endpackage

// ===== design/iupac_mmc_cfg.sv =====
module iupac_mmc_cfg #(
	parameter int WINDOW_SYMBOLS = 64,
	parameter int MAX_PATTERN = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write_en,
	input  logic [iupac_mmc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [iupac_mmc_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [$clog2(WINDOW_SYMBOLS+1)-1:0] span,
	output logic [3:0] exp_mask [WINDOW_SYMBOLS],
	output logic in_span [WINDOW_SYMBOLS]
);

	localparam int SPAN_W = $clog2(WINDOW_SYMBOLS + 1);
	localparam int MR_W = $clog2(WINDOW_SYMBOLS + 1);
	localparam int MAXL_A = (MAX_PATTERN < iupac_mmc_pkg::PATTERN_SLOTS) ?
		MAX_PATTERN : iupac_mmc_pkg::PATTERN_SLOTS;
	localparam int MAXL = (MAXL_A < WINDOW_SYMBOLS) ? MAXL_A : WINDOW_SYMBOLS;

	logic [63:0] pattern_codes_q;
	logic [4:0]  pattern_length_q;
	logic [2:0]  repeat_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_codes_q  <= '0;
			pattern_length_q <= 5'd1;
			repeat_count_q   <= 3'd1;
		end else if (cfg_write_en) begin
			unique case (iupac_mmc_pkg::cfg_reg_t'(cfg_index))
				iupac_mmc_pkg::CFG_PATTERN_CODES:  pattern_codes_q  <= cfg_data;
				iupac_mmc_pkg::CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[4:0];
				iupac_mmc_pkg::CFG_REPEAT_COUNT:   repeat_count_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Clamp length and repeat count, then form the match span.
	logic [MR_W-1:0] maxrep_tab [iupac_mmc_pkg::PATTERN_SLOTS];
	logic [4:0] len_c;
	logic [3:0] len_m1;
	logic [2:0] rep_c;
	logic [SPAN_W-1:0] span_c;

	for (genvar l = 0; l < iupac_mmc_pkg::PATTERN_SLOTS; l++) begin : g_maxrep
		localparam int REPS = WINDOW_SYMBOLS / (l + 1);
		assign maxrep_tab[l] = MR_W'(REPS);
	end

	always_comb begin
		if (pattern_length_q == 5'd0) begin
			len_c = 5'd1;
		end else if (pattern_length_q > 5'(MAXL)) begin
			len_c = 5'(MAXL);
		end else begin
			len_c = pattern_length_q;
		end
		len_m1 = 4'(len_c - 5'd1);
		if (repeat_count_q == 3'd0) begin
			rep_c = 3'd1;
		end else if (MR_W'(repeat_count_q) > maxrep_tab[len_m1]) begin
			rep_c = 3'(maxrep_tab[len_m1]);
		end else begin
			rep_c = repeat_count_q;
		end
		span_c = SPAN_W'({3'b000, len_c} * {5'b00000, rep_c});
	end

	// Window position j (0 is the newest symbol) checks against pattern slot
	// len-1 - (j mod len), since the span is a whole number of pattern lengths.
	logic [3:0] exp_d [WINDOW_SYMBOLS];
	logic in_span_d [WINDOW_SYMBOLS];

	for (genvar j = 0; j < WINDOW_SYMBOLS; j++) begin : g_pos
		logic [3:0] mod_tab [iupac_mmc_pkg::PATTERN_SLOTS];
		logic [3:0] slot;
		for (genvar l = 0; l < iupac_mmc_pkg::PATTERN_SLOTS; l++) begin : g_mod
			localparam int POS_MOD = j % (l + 1);
			assign mod_tab[l] = 4'(POS_MOD);
		end
		assign slot = len_m1 - mod_tab[len_m1];
		assign exp_d[j] = pattern_codes_q[{slot, 2'b00} +: 4];
		assign in_span_d[j] = span_c > SPAN_W'(j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				exp_mask[j] <= '0;
				in_span[j]  <= 1'(j == 0);
			end else begin
				exp_mask[j] <= exp_d[j];
				in_span[j]  <= in_span_d[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span <= SPAN_W'(1);
		end else begin
			span <= span_c;
		end
	end

endmodule

// ===== design/iupac_mmc_match.sv =====
module iupac_mmc_match #(
	parameter int WINDOW_SYMBOLS = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  iupac_mmc_pkg::step_t ctl,
	input  logic [7:0] text_byte,
	input  logic end_of_text,
	input  logic [$clog2(WINDOW_SYMBOLS+1)-1:0] span,
	input  logic [3:0] exp_mask [WINDOW_SYMBOLS],
	input  logic in_span [WINDOW_SYMBOLS],
	output logic match_found,
	output logic [31:0] match_start,
	output logic [31:0] match_total,
	output logic final_result
);

	localparam int SPAN_W = $clog2(WINDOW_SYMBOLS + 1);
	localparam int BLK_W = $clog2(WINDOW_SYMBOLS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [7:0] byte_s1;
	logic last_s1;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_text;
		end
	end

	logic [3:0] win_q [WINDOW_SYMBOLS];
	logic [31:0] seen_q;
	logic [BLK_W-1:0] blocked_q;
	logic [COUNT_BITS-1:0] count_q;

	logic space;
	logic [3:0] win_n [WINDOW_SYMBOLS];
	logic [WINDOW_SYMBOLS-1:0] pos_ok;
	logic [SPAN_W-1:0] span_m1;
	logic found;
	logic [31:0] start;
	logic [COUNT_BITS-1:0] count_n;

	assign space = iupac_mmc_pkg::is_space(byte_s1);
	assign span_m1 = span - SPAN_W'(1);

	// Each text code must be a subset of the pattern code at its position.
	for (genvar j = 0; j < WINDOW_SYMBOLS; j++) begin : g_win
		if (j == 0) begin : g_head
			assign win_n[j] = iupac_mmc_pkg::encode_base(byte_s1);
		end else begin : g_tail
			assign win_n[j] = win_q[j-1];
		end
		assign pos_ok[j] = !in_span[j] || ((win_n[j] & ~exp_mask[j]) == 4'h0);
	end

	always_comb begin
		found = !space && (blocked_q == '0) && (seen_q >= 32'(span_m1)) && (&pos_ok);
		start = found ? (seen_q - 32'(span_m1)) : 32'd0;
		count_n = (found && (count_q != COUNT_MAX)) ? (count_q + 1'b1) : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < WINDOW_SYMBOLS; j++) begin
				win_q[j] <= '0;
			end
			seen_q    <= '0;
			blocked_q <= '0;
			count_q   <= '0;
		end else if (ctl.process) begin
			if (last_s1) begin
				for (int j = 0; j < WINDOW_SYMBOLS; j++) begin
					win_q[j] <= '0;
				end
				seen_q    <= '0;
				blocked_q <= '0;
				count_q   <= '0;
			end else if (!space) begin
				for (int j = 0; j < WINDOW_SYMBOLS; j++) begin
					win_q[j] <= win_n[j];
				end
				if (blocked_q != '0) begin
					blocked_q <= blocked_q - 1'b1;
				end else if (found) begin
					blocked_q <= BLK_W'(span_m1);
				end
				if (seen_q != 32'hFFFF_FFFF) begin
					seen_q <= seen_q + 32'd1;
				end
				count_q <= count_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.process) begin
			match_found  <= found;
			match_start  <= start;
			match_total  <= 32'(count_n);
			final_result <= last_s1;
		end
	end

`ifndef SYNTHESIS
	a_block_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.process && found && !last_s1 |=> blocked_q == BLK_W'($past(span_m1)))
		else $error("blocking count not loaded after a match");

	a_no_match_while_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.process && (blocked_q != '0) |-> !found)
		else $error("match reported inside a blocked stretch");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.process && last_s1 |=> (seen_q == '0) && (count_q == '0) && (blocked_q == '0))
		else $error("state not cleared after end of text");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.process && !last_s1 |=> count_q >= $past(count_q))
		else $error("match count went down");
`endif

endmodule

// ===== design/iupac_masked_motif_counter_core.sv =====
// Channel     | Handshake            | Payload
// ------------+----------------------+-------------------------------------------------
// input       | in_valid / in_stall  | text_byte, end_of_text
// output      | out_valid / out_stall| match_found, match_start, match_total, final_result
// config      | cfg_write_en         | cfg_index, cfg_data (no wait, no read-back)
//
// One word is taken per cycle while in_stall is low; it is held in the input register,
// and its result word is held in the output register until the receiver takes it.
// The whole window compare is combinational between the input register and the output
// register, so the sustained rate is one word per clock with no stalls downstream.
// Reset is asynchronous and active low; it clears the window, counters and valid flags
// and loads the configuration reset values (length 1, one repeat, empty pattern).
// A stalled output holds its word; the input stalls only while both stages are full
// and the output is stalled.
// Configuration writes take effect for any word accepted after the write edge.
module iupac_masked_motif_counter_core #(
	parameter int WINDOW_SYMBOLS = 64,
	parameter int MAX_PATTERN = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,

	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] text_byte,
	input  logic end_of_text,

	output logic out_valid,
	input  logic out_stall,
	output logic match_found,
	output logic [31:0] match_start,
	output logic [31:0] match_total,
	output logic final_result,

	input  logic cfg_write_en,
	input  logic [iupac_mmc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [iupac_mmc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int SPAN_W = $clog2(WINDOW_SYMBOLS + 1);

	// The configuration block holds the registers and, every cycle, turns them into
	// the clamped span and one expected base-set mask per window position.
	logic [SPAN_W-1:0] span;
	logic [3:0] exp_mask [WINDOW_SYMBOLS];
	logic in_span [WINDOW_SYMBOLS];

	iupac_mmc_cfg #(
		.WINDOW_SYMBOLS(WINDOW_SYMBOLS),
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.span(span),
		.exp_mask(exp_mask),
		.in_span(in_span)
	);

	// Two-stage pipeline control. The output stage moves whenever it is empty or
	// being taken; the input stage refills in the same cycle it drains, so the
	// input register and the output register together act as the skid between
	// the two channels.
	logic s1_valid_q;
	logic out_valid_q;
	logic advance;
	iupac_mmc_pkg::step_t step;

	assign advance = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !advance;
	assign step.capture = in_valid && !in_stall;
	assign step.process = s1_valid_q && advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				s1_valid_q <= in_valid;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// The datapath encodes the registered byte, shifts it into the window, tests
	// the window against the pattern, applies the non-overlap blocking and the
	// saturating counters, and registers the result word.
	iupac_mmc_match #(
		.WINDOW_SYMBOLS(WINDOW_SYMBOLS),
		.COUNT_BITS(COUNT_BITS)
	) u_match (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(step),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.span(span),
		.exp_mask(exp_mask),
		.in_span(in_span),
		.match_found(match_found),
		.match_start(match_start),
		.match_total(match_total),
		.final_result(final_result)
	);

endmodule

// ===== tb/iupac_masked_motif_counter_core_test.sv =====
`timescale 1ns / 1ps

import iupac_mmc_pkg::*;

// One result word as the block reports it.
typedef struct packed {
	logic        found;
	logic [31:0] start;
	logic [31:0] total;
	logic        last;
} match_word_t;

// Tracks the motif counter's state and the result words still owed by the block.
class motif_scoreboard;
	logic [63:0] pattern_masks;
	logic [4:0]  length_reg;
	logic [2:0]  repeat_reg;
	logic [3:0]  window [64];
	logic [31:0] symbol_index;
	int unsigned blocked_left;
	logic [31:0] match_count;
	match_word_t awaited [$];
	int unsigned failures;
	int unsigned words_checked;
	int unsigned matches_checked;
	int unsigned texts_ended;

	function new();
		pattern_masks = '0;
		length_reg = 5'd1;
		repeat_reg = 3'd1;
		failures = 0;
		words_checked = 0;
		matches_checked = 0;
		texts_ended = 0;
		clear_text();
	endfunction

	function void clear_text();
		foreach (window[i])
			window[i] = 4'h0;
		symbol_index = '0;
		blocked_left = 0;
		match_count = '0;
	endfunction

	function void write_reg(cfg_reg_t idx, logic [63:0] value);
		case (idx)
			CFG_PATTERN_CODES: pattern_masks = value;
			CFG_PATTERN_LENGTH: length_reg = value[4:0];
			CFG_REPEAT_COUNT: repeat_reg = value[2:0];
			default: ;
		endcase
	endfunction

	// Pattern length and total span after clamping to what the window can hold.
	function void geometry(output int unsigned len, output int unsigned span);
		int unsigned rep;
		len = length_reg;
		if (len < 1)
			len = 1;
		if (len > PATTERN_SLOTS)
			len = PATTERN_SLOTS;
		rep = repeat_reg;
		if (rep < 1)
			rep = 1;
		if (rep > 64 / len)
			rep = 64 / len;
		span = len * rep;
	endfunction

	function logic [3:0] base_set(logic [7:0] ch);
		logic [7:0] up;
		logic [3:0] set;
		up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
		case (up)
			"A": set = BASE_A;
			"T": set = BASE_T;
			"G": set = BASE_G;
			"C": set = BASE_C;
			"M": set = BASE_A | BASE_C;
			"R": set = BASE_A | BASE_G;
			"W": set = BASE_A | BASE_T;
			"S": set = BASE_C | BASE_G;
			"Y": set = BASE_C | BASE_T;
			"K": set = BASE_G | BASE_T;
			"V": set = BASE_A | BASE_C | BASE_G;
			"H": set = BASE_A | BASE_C | BASE_T;
			"D": set = BASE_A | BASE_G | BASE_T;
			"B": set = BASE_C | BASE_G | BASE_T;
			"X", "N": set = 4'hF;
			default: set = 4'h0;
		endcase
		return set;
	endfunction

	function void note_word(logic [7:0] ch, logic eot);
		int unsigned len;
		int unsigned span;
		int unsigned i;
		logic [3:0] mask;
		bit fits;
		match_word_t w;
		w = '0;
		w.last = eot;
		if (!(ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D))) begin
			geometry(len, span);
			for (i = 63; i > 0; i--)
				window[i] = window[i - 1];
			window[0] = base_set(ch);
			if (blocked_left > 0) begin
				blocked_left--;
			end else if (longint'(symbol_index) + 1 >= span) begin
				fits = 1'b1;
				for (i = 0; i < span; i++) begin
					mask = pattern_masks[4 * (i % len) +: 4];
					if ((window[span - 1 - i] & ~mask) != 4'h0)
						fits = 1'b0;
				end
				if (fits) begin
					w.found = 1'b1;
					w.start = symbol_index + 32'd1 - span;
					if (match_count != '1)
						match_count++;
					blocked_left = span - 1;
				end
			end
			if (symbol_index != '1)
				symbol_index++;
		end
		w.total = match_count;
		awaited.push_back(w);
		if (eot)
			clear_text();
	endfunction

	function void check_word(match_word_t got);
		match_word_t want;
		if (awaited.size() == 0) begin
			$error("result word arrived with no prediction pending");
			failures++;
			return;
		end
		want = awaited.pop_front();
		words_checked++;
		if (got.found !== want.found) begin
			$error("match_found: expected %0d, got %0d", want.found, got.found);
			failures++;
		end
		if (got.start !== want.start) begin
			$error("match_start: expected %0d, got %0d", want.start, got.start);
			failures++;
		end
		if (got.total !== want.total) begin
			$error("match_total: expected %0d, got %0d", want.total, got.total);
			failures++;
		end
		if (got.last !== want.last) begin
			$error("final_result: expected %0d, got %0d", want.last, got.last);
			failures++;
		end
		if (want.found)
			matches_checked++;
		if (want.last)
			texts_ended++;
	endfunction
endclass

module iupac_masked_motif_counter_core_test;

	// Cycles with no word moving on either channel before the run is declared hung.
	localparam int STALL_LIMIT = 3000;
	// Quiet cycles after the last result before registers change or the run ends.
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PHASES = 8;
	// Length of the deliberate output hold that backs the block up.
	localparam int LONG_HOLD = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] text_byte = 8'h00;
	logic end_of_text = 1'b0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic match_found;
	logic [31:0] match_start;
	logic [31:0] match_total;
	logic final_result;

	logic cfg_write_en = 1'b0;
	cfg_reg_t cfg_index = CFG_PATTERN_CODES;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	motif_scoreboard sb = new();

	// Percent chances that the sender idles or the receiver stalls in a given cycle.
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	// Set by the stimulus to ask the receiver for one long hold-off.
	int unsigned hold_request = 0;
	int unsigned words_sent = 0;
	int unsigned settings_used = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	iupac_masked_motif_counter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.match_found(match_found),
		.match_start(match_start),
		.match_total(match_total),
		.final_result(final_result),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Offers one word after a random number of idle cycles and holds it until the
	// block takes it. The prediction is made at the edge where the word is accepted.
	task automatic send_word(input logic [7:0] ch, input logic eot);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(0, 99) < gap_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= ch;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(ch, eot);
		words_sent++;
	endtask

	task automatic send_text(input string s, input bit end_at_last);
		int k;
		for (k = 0; k < s.len(); k++)
			send_word(s[k], end_at_last && (k == s.len() - 1));
	endtask

	// Stops offering words and waits until every predicted result has come back,
	// then lets the pipeline settle. Registers may only change after this.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The write enable is left high so that writes can follow back to back.
	task automatic write_cfg(input cfg_reg_t idx, input logic [63:0] value);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	// Loads all three registers. The narrow registers get random upper data bits,
	// which the block has to ignore.
	task automatic apply_settings(input logic [63:0] pat, input logic [4:0] len,
			input logic [2:0] rep);
		logic [63:0] value;
		wait_for_drain();
		write_cfg(CFG_PATTERN_CODES, pat);
		value = {$urandom(), $urandom()};
		value[4:0] = len;
		write_cfg(CFG_PATTERN_LENGTH, value);
		value = {$urandom(), $urandom()};
		value[2:0] = rep;
		write_cfg(CFG_REPEAT_COUNT, value);
		cfg_write_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic [7:0] blank_char();
		int unsigned pick;
		pick = $urandom_range(0, 5);
		return (pick == 5) ? 8'h20 : 8'h09 + 8'(pick);
	endfunction

	// A letter in either case whose base set lies inside the given mask. When no
	// letter fits, an unknown character stands in, since it matches any mask.
	function automatic logic [7:0] fitting_char(input logic [3:0] mask);
		string letters;
		logic [7:0] ch;
		letters = "ACGTMRWSYKVHDBXN";
		for (int t = 0; t < 24; t++) begin
			ch = letters[$urandom_range(0, 15)];
			if ((sb.base_set(ch) & ~mask) == 4'h0)
				return ($urandom_range(0, 1) != 0) ? ch + 8'd32 : ch;
		end
		return 8'h2D;
	endfunction

	// Random text built mostly from whole copies of the repeated pattern, so that
	// matches, blocking after a match and back-to-back matches all occur. Copies
	// are salted with whitespace and stray bytes, and noise runs shift the
	// alignment. A text now and then ends with end_of_text on its last word.
	task automatic send_motif_text(input int unsigned quota);
		int unsigned target;
		int unsigned len;
		int unsigned span;
		int unsigned k;
		logic [7:0] seg [$];
		bit end_here;
		target = words_sent + quota;
		sb.geometry(len, span);
		while (words_sent < target) begin
			seg.delete();
			if ($urandom_range(0, 99) < 80) begin
				for (k = 0; k < span; k++) begin
					if ($urandom_range(0, 99) < 8)
						seg.push_back(blank_char());
					if ($urandom_range(0, 99) < 4)
						seg.push_back(8'($urandom_range(0, 255)));
					else
						seg.push_back(fitting_char(sb.pattern_masks[4 * (k % len) +: 4]));
				end
			end else begin
				repeat ($urandom_range(1, 6)) seg.push_back(8'($urandom_range(0, 255)));
			end
			end_here = ($urandom_range(0, 99) < 6);
			foreach (seg[j])
				send_word(seg[j], end_here && (j == seg.size() - 1));
		end
	endtask

	// Result side: every accepted word is checked against the oldest prediction.
	// The stall for the next edge is chosen here, either at random or as part of a
	// long hold that the stimulus asked for.
	initial begin : result_sink
		int unsigned hold_left;
		match_word_t got;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got = {match_found, match_start, match_total, final_result};
				sb.check_word(got);
			end
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Ends the run if neither channel moves a word for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [63:0] pat;
		logic [4:0] len;
		logic [2:0] rep;
		int unsigned p;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: an empty pattern of length one, so only unknown bytes
		// match. Whitespace moves nothing, bytes above 0x7F and the NUL byte count
		// as unknown, and the text ends on the NUL.
		send_text("za \t", 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h00, 1'b1);

		// Two repeats of R Y: the first match is followed by a blocked stretch and
		// then an adjacent match, with mixed case and a line feed in between.
		apply_settings(64'hA5, 5'd2, 3'd2);
		send_text("AcGtgT\nAcN", 1'b1);

		// Zero length and zero repeats clamp to one, a full pattern matches every
		// symbol, and the text ends on a whitespace word.
		apply_settings('1, 5'd0, 3'd0);
		send_text("Nq", 1'b0);
		send_word(8'h0B, 1'b0);
		send_word(8'h0C, 1'b0);
		send_word(8'h0D, 1'b1);

		// Random phases. Texts are not always ended before a register change, so
		// the window and any blocking carry over into the new setting.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			pat = {$urandom(), $urandom()} | {$urandom(), $urandom()};
			len = 5'($urandom_range(1, 8));
			rep = 3'($urandom_range(1, 4));
			case (p)
				0: begin
					len = 5'd1;
					rep = 3'd1;
				end
				1: begin
					len = 5'd16;
					rep = 3'd4;
				end
				2: begin
					len = 5'd0;
					rep = 3'd0;
				end
				3: begin
					// Clamps to sixteen positions and four repeats: the full window.
					len = 5'd31;
					rep = 3'd7;
				end
				4: pat = '0;
				5: pat = '1;
				default: ;
			endcase
			apply_settings(pat, len, rep);
			case (p % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 69;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 69;
				end
				default: begin
					gap_pct = 35;
					stall_pct = 35;
				end
			endcase
			// In the first free-flowing phase the receiver holds off while the
			// sender keeps offering, which fills the block and stalls its input.
			if (p == 0)
				hold_request = LONG_HOLD;
			send_motif_text((p == 1 || p == 3) ? 130 : 65);
		end

		wait_for_drain();
		$display("Checked %0d result words: %0d matches, %0d ends of text, %0d settings.",
			sb.words_checked, sb.matches_checked, sb.texts_ended, settings_used);
		$display("Phases ran free, with sender gaps, receiver stalls, both, and a long hold.");
		if (sb.failures == 0 && sb.awaited.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
